### sv/cpqm_pkg.sv
// cpqm_pkg: types and fixed constants for the cascaded PID quad mixer.
// No dependencies; imported by cascaded_pid_quad_mixer_unit.
`default_nettype none

package cpqm_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_RATE_X,
        ST_RATE_Y,
        ST_RATE_Z,
        ST_ANG_R,
        ST_ANG_P,
        ST_TGT_R,
        ST_TGT_P,
        ST_TGT_Y,
        ST_ERR,
        ST_INTEG,
        ST_PROP,
        ST_DERIV,
        ST_RATEMUL,
        ST_SUM,
        ST_MIX
    } t_state;

    typedef enum logic [2:0] {
        CFG_OUTER_KP,
        CFG_INNER_KP,
        CFG_INNER_KI_RP,
        CFG_INNER_KI_YAW,
        CFG_INNER_KD,
        CFG_STEP_SECONDS,
        CFG_STEP_RATE_HZ,
        CFG_OUTPUT_LIMIT
    } t_cfg_idx;

    localparam int CENTRE_US    = 1500;
    localparam int ARM_MIN_US   = 1100;
    localparam int MOTOR_MIN_US = 1000;
    localparam int MOTOR_MAX_US = 2000;

    // constant divisions as reciprocal multiply plus one correction
    localparam int RECIP_SHIFT = 30;
    localparam int DIV_RATE    = 262;
    localparam int DIV_ANGLE   = 50;
    localparam int DIV_YAW     = 5;
    localparam int RATE_OFS    = 128100;
    localparam int ANGLE_OFS   = CENTRE_US * 768 / DIV_ANGLE;
    localparam int RATE_BIAS   = DIV_RATE * RATE_OFS + DIV_RATE / 2;

    localparam logic [38:0] RECIP_RATE  = 39'((64'd1 << RECIP_SHIFT) / DIV_RATE);
    localparam logic [38:0] RECIP_ANGLE = 39'((64'd1 << RECIP_SHIFT) / DIV_ANGLE);
    localparam logic [38:0] RECIP_YAW   = 39'((64'd1 << RECIP_SHIFT) / DIV_YAW);

    localparam logic [15:0] RST_OUTER_KP   = 16'd128;
    localparam logic [15:0] RST_INNER_KP   = 16'd77;
    localparam logic [15:0] RST_KI_RP      = 16'd128;
    localparam logic [15:0] RST_KI_YAW     = 16'd51;
    localparam logic [15:0] RST_INNER_KD   = 16'd0;
    localparam logic [23:0] RST_STEP_S     = 24'd33554;
    localparam logic [15:0] RST_STEP_HZ    = 16'd500;
    localparam logic [10:0] RST_OUT_LIMIT  = 11'd500;

endpackage

`default_nettype wire

### sv/cascaded_pid_quad_mixer_unit.sv
// cascaded_pid_quad_mixer_unit: angle/rate PID cascade with X-form motor mixer.
// One shared signed multiplier under a state sequencer; uses cpqm_pkg.
`default_nettype none
//
// channel   dir  handshake                  payload
// s (in)    in   i_s_tvalid / o_s_tready    i_s_tdata: angles, gyros, sticks
// m (out)   out  o_m_tvalid / i_m_tready    o_m_tdata: motors; o_m_tuser: armed
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Armed beat: the idle step that takes the beat, then the sequencer (9 pre steps,
// 6 per axis, 1 mix); most steps are one pass through the shared 39x28
// multiplier. Disarm beat: the sequencer goes from the start step to the mix step.
// A new beat is taken only in idle; the output register frees the sequencer
// once its result is stored, a stalled output holds the mix step.
// Synchronous active-low reset: registers to defaults, integrators cleared,
// held motor commands 1000.

module cascaded_pid_quad_mixer_unit #(
    parameter int INTEGRAL_LIMIT = 200
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // roll_angle[16:0] pitch_angle[33:17] gyro_x_raw[49:34] gyro_y_raw[65:50]
    // gyro_z_raw[81:66] roll_stick[93:82] pitch_stick[105:94] yaw_stick[117:106]
    // throttle_stick[129:118], zero pad
    input  wire logic [135:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // motor_1[10:0] motor_2[21:11] motor_3[32:22] motor_4[43:33], zero pad
    output logic [47:0]       o_m_tdata,
    // armed[0]
    output logic              o_m_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [23:0]  i_cfg_data
);
    import cpqm_pkg::*;

    localparam logic signed [39:0] ILIM = 40'(INTEGRAL_LIMIT) <<< 16;

    t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;

    logic [15:0] r_outer_kp, r_inner_kp, r_ki_rp, r_ki_yaw, r_inner_kd, r_step_hz;
    logic [23:0] r_step_s;
    logic [10:0] r_out_limit;

    logic signed [16:0] r_roll_ang, r_pitch_ang;
    logic signed [15:0] r_gx, r_gy, r_gz;
    logic [11:0] r_rs, r_ps, r_ys, r_thr;
    logic r_arm;

    logic signed [18:0] r_rate [3];
    logic signed [20:0] r_tgt [3];
    logic signed [20:0] r_pid [3];
    logic signed [31:0] r_integ [3];
    logic signed [20:0] r_prev [3];
    logic signed [18:0] r_err_r, r_err_p;
    logic signed [20:0] r_e;
    logic signed [63:0] r_acc;
    logic [10:0] r_held [4];

    logic signed [38:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [66:0] r_prod;
    logic [26:0] r_num;

    logic r_o_valid, r_armed;
    logic [10:0] r_m [4];

    logic out_free, accept, disarm;
    logic [18:0] lim;
    logic [18:0] q_est;
    logic [28:0] rem_rate, rem_angle, rem_yaw;
    logic [18:0] q_rate, q_angle, q_yaw;
    logic signed [20:0] e_cur;
    logic signed [21:0] diff;
    logic signed [66:0] integ_add;
    logic signed [39:0] integ_sum;
    logic signed [31:0] integ_new;
    logic signed [63:0] acc_hi, tot;
    logic signed [20:0] outer_pid, sum_pid;
    logic signed [19:0] ang_t;
    logic signed [22:0] thr_s;
    logic signed [22:0] mix [4];
    logic [10:0] motor [4];

    function automatic logic signed [20:0] clamp_pid(input logic signed [66:0] v,
                                                    input logic [18:0] l);
        logic signed [66:0] hi;
        hi = $signed({48'd0, l});
        if (v > hi) begin
            return hi[20:0];
        end else if (v < -hi) begin
            return -hi[20:0];
        end
        return v[20:0];
    endfunction

    function automatic logic [10:0] motor_clamp(input logic signed [22:0] m);
        if (m > 23'sd512000) begin
            return 11'(MOTOR_MAX_US);
        end else if (m < 23'sd256000) begin
            return 11'(MOTOR_MIN_US);
        end
        return m[18:8];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_o_valid || i_m_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign disarm      = (r_thr < 12'(ARM_MIN_US));
    assign lim         = {r_out_limit, 8'd0};

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {4'd0, r_m[3], r_m[2], r_m[1], r_m[0]};
    assign o_m_tuser  = r_armed;

    // reciprocal correction for the three constant divisors
    always_comb begin
        q_est     = r_prod[RECIP_SHIFT+18:RECIP_SHIFT];
        rem_rate  = {2'd0, r_num} - 29'(q_est) * 29'(DIV_RATE);
        rem_angle = {2'd0, r_num} - 29'(q_est) * 29'(DIV_ANGLE);
        rem_yaw   = {2'd0, r_num} - 29'(q_est) * 29'(DIV_YAW);
        q_rate    = q_est + 19'(rem_rate >= 29'(DIV_RATE));
        q_angle   = q_est + 19'(rem_angle >= 29'(DIV_ANGLE));
        q_yaw     = q_est + 19'(rem_yaw >= 29'(DIV_YAW));
        ang_t     = $signed({1'b0, q_angle}) - 20'(ANGLE_OFS);
    end

    always_comb begin
        e_cur     = r_tgt[r_axis] - 21'(r_rate[r_axis]);
        diff      = 22'(r_e) - 22'(r_prev[r_axis]);
        integ_add = (r_prod + 67'sd32768) >>> 16;
        integ_sum = 40'(r_integ[r_axis]) + integ_add[39:0];
        if (integ_sum > ILIM) begin
            integ_new = ILIM[31:0];
        end else if (integ_sum < -ILIM) begin
            integ_new = -ILIM[31:0];
        end else begin
            integ_new = integ_sum[31:0];
        end
        acc_hi    = {r_prod[55:0], 8'd0};
        tot       = r_acc + r_prod[63:0];
        outer_pid = clamp_pid((r_prod + 67'sd128) >>> 8, lim);
        sum_pid   = clamp_pid(67'((tot + 64'sd32768) >>> 16), lim);
        thr_s     = $signed({3'd0, r_thr, 8'd0});
        mix[0]    = thr_s - 23'(r_pid[0]) + 23'(r_pid[1]) - 23'(r_pid[2]);
        mix[1]    = thr_s + 23'(r_pid[0]) + 23'(r_pid[1]) + 23'(r_pid[2]);
        mix[2]    = thr_s - 23'(r_pid[0]) - 23'(r_pid[1]) + 23'(r_pid[2]);
        mix[3]    = thr_s + 23'(r_pid[0]) - 23'(r_pid[1]) - 23'(r_pid[2]);
        for (int i = 0; i < 4; i++) begin
            motor[i] = r_arm ? motor_clamp(mix[i]) : r_held[i];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            ST_IDLE:    if (accept) n_state = ST_START;
            ST_START:   n_state = disarm ? ST_MIX : ST_RATE_X;
            ST_RATE_X:  n_state = ST_RATE_Y;
            ST_RATE_Y:  n_state = ST_RATE_Z;
            ST_RATE_Z:  n_state = ST_ANG_R;
            ST_ANG_R:   n_state = ST_ANG_P;
            ST_ANG_P:   n_state = ST_TGT_R;
            ST_TGT_R:   n_state = ST_TGT_P;
            ST_TGT_P:   n_state = ST_TGT_Y;
            ST_TGT_Y: begin
                n_state = ST_ERR;
                n_axis  = 2'd0;
            end
            ST_ERR:     n_state = ST_INTEG;
            ST_INTEG:   n_state = ST_PROP;
            ST_PROP:    n_state = ST_DERIV;
            ST_DERIV:   n_state = ST_RATEMUL;
            ST_RATEMUL: n_state = ST_SUM;
            ST_SUM: begin
                if (r_axis == 2'd2) begin
                    n_state = ST_MIX;
                end else begin
                    n_state = ST_ERR;
                    n_axis  = r_axis + 2'd1;
                end
            end
            ST_MIX:     if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // multiplier operands per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_START: begin
                mul_a = RECIP_RATE;
                mul_b = 28'({{2{r_gx[15]}}, r_gx, 10'd0}) + 28'(RATE_BIAS);
            end
            ST_RATE_X: begin
                mul_a = RECIP_RATE;
                mul_b = 28'({{2{r_gy[15]}}, r_gy, 10'd0}) + 28'(RATE_BIAS);
            end
            ST_RATE_Y: begin
                mul_a = RECIP_RATE;
                mul_b = 28'({{2{r_gz[15]}}, r_gz, 10'd0}) + 28'(RATE_BIAS);
            end
            ST_RATE_Z: begin
                mul_a = RECIP_ANGLE;
                mul_b = 28'(r_rs) * 28'd768 + 28'(DIV_ANGLE / 2);
            end
            ST_ANG_R: begin
                mul_a = RECIP_ANGLE;
                mul_b = 28'(r_ps) * 28'd768 + 28'(DIV_ANGLE / 2);
            end
            ST_ANG_P: begin
                mul_a = 39'(r_err_r);
                mul_b = {12'd0, r_outer_kp};
            end
            ST_TGT_R: begin
                mul_a = 39'(r_err_p);
                mul_b = {12'd0, r_outer_kp};
            end
            ST_TGT_P: begin
                mul_a = RECIP_YAW;
                mul_b = (r_ys >= 12'(CENTRE_US))
                      ? {8'd0, 12'(r_ys - 12'(CENTRE_US)), 8'd0}
                      : {8'd0, 12'(12'(CENTRE_US) - r_ys), 8'd0};
            end
            ST_ERR: begin
                mul_a = 39'(e_cur);
                mul_b = {4'd0, r_step_s};
            end
            ST_INTEG: begin
                mul_a = 39'(r_e);
                mul_b = {12'd0, r_inner_kp};
            end
            ST_PROP: begin
                mul_a = 39'(diff);
                mul_b = {12'd0, r_inner_kd};
            end
            ST_DERIV: begin
                mul_a = r_prod[38:0];
                mul_b = {12'd0, r_step_hz};
            end
            ST_RATEMUL: begin
                mul_a = 39'(r_integ[r_axis]);
                mul_b = {12'd0, (r_axis == 2'd2) ? r_ki_yaw : r_ki_rp};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= 67'(mul_a) * 67'(mul_b);
        r_num  <= mul_b[26:0];
        if (accept) begin
            r_roll_ang  <= i_s_tdata[16:0];
            r_pitch_ang <= i_s_tdata[33:17];
            r_gx        <= i_s_tdata[49:34];
            r_gy        <= i_s_tdata[65:50];
            r_gz        <= i_s_tdata[81:66];
            r_rs        <= i_s_tdata[93:82];
            r_ps        <= i_s_tdata[105:94];
            r_ys        <= i_s_tdata[117:106];
            r_thr       <= i_s_tdata[129:118];
        end
        case (r_state)
            ST_START:   r_arm <= !disarm;
            ST_RATE_X:  r_rate[0] <= $signed(q_rate) - 19'(RATE_OFS);
            ST_RATE_Y:  r_rate[1] <= $signed(q_rate) - 19'(RATE_OFS);
            ST_RATE_Z:  r_rate[2] <= $signed(q_rate) - 19'(RATE_OFS);
            ST_ANG_R:   r_err_r <= 19'(ang_t) - 19'(r_roll_ang);
            ST_ANG_P:   r_err_p <= 19'(ang_t) - 19'(r_pitch_ang);
            ST_TGT_R:   r_tgt[0] <= outer_pid;
            ST_TGT_P:   r_tgt[1] <= outer_pid;
            ST_TGT_Y:   r_tgt[2] <= (r_ys >= 12'(CENTRE_US)) ? 21'(q_yaw) : -21'(q_yaw);
            ST_ERR:     r_e <= e_cur;
            ST_PROP:    r_acc <= acc_hi;
            ST_RATEMUL: r_acc <= r_acc + acc_hi;
            ST_SUM:     r_pid[r_axis] <= sum_pid;
            default: ;
        endcase
    end

    // control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 2'd0;
            r_o_valid   <= 1'b0;
            r_outer_kp  <= RST_OUTER_KP;
            r_inner_kp  <= RST_INNER_KP;
            r_ki_rp     <= RST_KI_RP;
            r_ki_yaw    <= RST_KI_YAW;
            r_inner_kd  <= RST_INNER_KD;
            r_step_s    <= RST_STEP_S;
            r_step_hz   <= RST_STEP_HZ;
            r_out_limit <= RST_OUT_LIMIT;
            for (int i = 0; i < 3; i++) begin
                r_integ[i] <= '0;
                r_prev[i]  <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_held[i] <= 11'(MOTOR_MIN_US);
            end
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OUTER_KP:     r_outer_kp  <= i_cfg_data[15:0];
                    CFG_INNER_KP:     r_inner_kp  <= i_cfg_data[15:0];
                    CFG_INNER_KI_RP:  r_ki_rp     <= i_cfg_data[15:0];
                    CFG_INNER_KI_YAW: r_ki_yaw    <= i_cfg_data[15:0];
                    CFG_INNER_KD:     r_inner_kd  <= i_cfg_data[15:0];
                    CFG_STEP_SECONDS: r_step_s    <= i_cfg_data;
                    CFG_STEP_RATE_HZ: r_step_hz   <= i_cfg_data[15:0];
                    CFG_OUTPUT_LIMIT: r_out_limit <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (r_state == ST_START && disarm) begin
                for (int i = 0; i < 3; i++) begin
                    r_integ[i] <= '0;
                    r_prev[i]  <= '0;
                end
            end
            if (r_state == ST_INTEG) begin
                r_integ[r_axis] <= integ_new;
            end
            if (r_state == ST_PROP) begin
                r_prev[r_axis] <= r_e;
            end
            if (r_state == ST_MIX && out_free) begin
                r_o_valid <= 1'b1;
                if (r_arm) begin
                    for (int i = 0; i < 4; i++) begin
                        r_held[i] <= motor[i];
                    end
                end
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MIX && out_free) begin
            r_armed <= r_arm;
            for (int i = 0; i < 4; i++) begin
                r_m[i] <= motor[i];
            end
        end
    end

endmodule

`default_nettype wire

### bench/tb_cascaded_pid_quad_mixer_unit.sv
// Testbench for cascaded_pid_quad_mixer_unit: drives flight-control ticks
// against a cycle-free predictor of the PID cascade and mixer; uses cpqm_pkg.
`default_nettype none

module tb_cascaded_pid_quad_mixer_unit;
    import cpqm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INTEG_LIM = 200;
    localparam int WATCHDOG  = 20000;

    typedef struct packed {
        logic [11:0] thr;
        logic [11:0] ys;
        logic [11:0] ps;
        logic [11:0] rs;
        logic [15:0] gz;
        logic [15:0] gy;
        logic [15:0] gx;
        logic [16:0] pa;
        logic [16:0] ra;
    } t_tick;

    typedef struct packed {
        logic [10:0] m4;
        logic [10:0] m3;
        logic [10:0] m2;
        logic [10:0] m1;
        logic        armed;
    } t_motors;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [135:0] i_s_tdata = '0;
    logic         i_m_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [23:0]  i_cfg_data = '0;
    logic         o_s_tready, o_m_tvalid, o_m_tuser, o_cfg_ready;
    logic [47:0]  o_m_tdata;

    cascaded_pid_quad_mixer_unit u_dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    longint gain_okp = 128, gain_ikp = 77, gain_kirp = 128, gain_kiy = 51, gain_kd = 0;
    longint dt_q24 = 33554, rate_hz = 500, out_lim = 500;
    longint integ_q[3];
    longint prev_err[3];
    longint held_cmd[4];

    t_tick   tick_q[$];
    t_motors motors_q[$];
    int      n_fail = 0;
    bit      feeding = 1'b0;
    int      hold_off = 0;

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint rshift(longint x, int s);
        return fdiv(x + (longint'(1) << (s - 1)), longint'(1) << s);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    function automatic longint rate_pid(int ax, longint rate, longint tgt, longint ki);
        longint e, ig, dv, tot;
        e  = tgt - rate;
        ig = clip(integ_q[ax] + rshift(e * dt_q24, 16),
                  -INTEG_LIM * 65536, INTEG_LIM * 65536);
        dv = (e - prev_err[ax]) * rate_hz;
        tot = gain_ikp * e * 256 + ki * ig + gain_kd * dv * 256;
        integ_q[ax] = ig;
        prev_err[ax] = e;
        return clip(rshift(tot, 16), -out_lim * 256, out_lim * 256);
    endfunction

    function automatic t_motors mix_predict(t_tick t);
        t_motors r;
        longint tr, tp, ty, ro, po, yo, thr, m[4];
        thr = t.thr;
        if (thr < ARM_MIN_US) begin
            for (int i = 0; i < 3; i++) begin
                integ_q[i] = 0;
                prev_err[i] = 0;
            end
            r = '{m1: 11'(held_cmd[0]), m2: 11'(held_cmd[1]), m3: 11'(held_cmd[2]),
                  m4: 11'(held_cmd[3]), armed: 1'b0};
            return r;
        end
        tr = fdiv((longint'(t.rs) - 1500) * 768 + 25, 50) - longint'($signed(t.ra));
        tp = fdiv((longint'(t.ps) - 1500) * 768 + 25, 50) - longint'($signed(t.pa));
        tr = clip(rshift(gain_okp * tr, 8), -out_lim * 256, out_lim * 256);
        tp = clip(rshift(gain_okp * tp, 8), -out_lim * 256, out_lim * 256);
        ty = (longint'(t.ys) - 1500) * 256 / 5;
        ro = rate_pid(0, fdiv(longint'($signed(t.gx)) * 1024 + 131, 262), tr, gain_kirp);
        po = rate_pid(1, fdiv(longint'($signed(t.gy)) * 1024 + 131, 262), tp, gain_kirp);
        yo = rate_pid(2, fdiv(longint'($signed(t.gz)) * 1024 + 131, 262), ty, gain_kiy);
        thr = thr * 256;
        m[0] = thr - ro + po - yo;
        m[1] = thr + ro + po + yo;
        m[2] = thr - ro - po + yo;
        m[3] = thr + ro - po - yo;
        for (int i = 0; i < 4; i++)
            held_cmd[i] = clip(m[i], 256000, 512000) >>> 8;
        r = '{m1: 11'(held_cmd[0]), m2: 11'(held_cmd[1]), m3: 11'(held_cmd[2]),
              m4: 11'(held_cmd[3]), armed: 1'b1};
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_fail++;
    endtask

    // driver
    int s_gap = 0;
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            motors_q.push_back(mix_predict(t_tick'(i_s_tdata[129:0])));
            void'(tick_q.pop_front());
            s_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) s_gap = 0;
        end
        if (i_s_tvalid && !o_s_tready) begin
        end else if (feeding && tick_q.size() > 0 && s_gap == 0) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata <= {6'b0, tick_q[0]};
        end else begin
            i_s_tvalid <= 1'b0;
            if (s_gap > 0) s_gap--;
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge i_clk) begin
        t_motors w;
        if (o_m_tvalid && i_m_tready) begin
            if (motors_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = motors_q.pop_front();
                if (o_m_tdata[10:0] !== w.m1) report_mismatch("motor_1", o_m_tdata[10:0], w.m1);
                if (o_m_tdata[21:11] !== w.m2) report_mismatch("motor_2", o_m_tdata[21:11], w.m2);
                if (o_m_tdata[32:22] !== w.m3) report_mismatch("motor_3", o_m_tdata[32:22], w.m3);
                if (o_m_tdata[43:33] !== w.m4) report_mismatch("motor_4", o_m_tdata[43:33], w.m4);
                if (o_m_tuser !== w.armed) report_mismatch("armed", o_m_tuser, w.armed);
            end
            m_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) m_gap = 0;
        end
        if (hold_off > 0) begin
            hold_off--;
            i_m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || hold_off > 0)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, longint val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[23:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_OUTER_KP:     gain_okp = val & 16'hFFFF;
            CFG_INNER_KP:     gain_ikp = val & 16'hFFFF;
            CFG_INNER_KI_RP:  gain_kirp = val & 16'hFFFF;
            CFG_INNER_KI_YAW: gain_kiy = val & 16'hFFFF;
            CFG_INNER_KD:     gain_kd = val & 16'hFFFF;
            CFG_STEP_SECONDS: dt_q24 = val & 24'hFFFFFF;
            CFG_STEP_RATE_HZ: rate_hz = val & 16'hFFFF;
            default:          out_lim = val & 11'h7FF;
        endcase
    endtask

    task automatic drain;
        feeding = 1'b1;
        while (tick_q.size() > 0 || motors_q.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        feeding = 1'b0;
    endtask

    function automatic t_tick rand_tick(bit well_formed);
        t_tick t;
        t = t_tick'(130'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        if (well_formed) begin
            t.ra = 17'($signed($urandom_range(0, 92160)) - 46080);
            t.pa = 17'($signed($urandom_range(0, 92160)) - 46080);
            t.rs = 12'($urandom_range(1000, 2000));
            t.ps = 12'($urandom_range(1000, 2000));
            t.ys = 12'($urandom_range(1000, 2000));
            t.thr = 12'(($urandom_range(0, 9) == 0) ? $urandom_range(900, 1099)
                                                    : $urandom_range(1100, 2000));
            if ($urandom_range(0, 1)) begin
                t.gx = 16'($signed($urandom_range(0, 4000)) - 2000);
                t.gy = 16'($signed($urandom_range(0, 4000)) - 2000);
                t.gz = 16'($signed($urandom_range(0, 4000)) - 2000);
            end
        end
        return t;
    endfunction

    function automatic t_tick fixed_tick(int ra, int pa, int g, int s, int thr);
        t_tick t;
        t.ra = 17'(ra); t.pa = 17'(pa);
        t.gx = 16'(g); t.gy = 16'(-g); t.gz = 16'(g);
        t.rs = 12'(s); t.ps = 12'(3000 - s); t.ys = 12'(s); t.thr = 12'(thr);
        return t;
    endfunction

    initial begin
        for (int i = 0; i < 3; i++) begin
            integ_q[i] = 0;
            prev_err[i] = 0;
        end
        for (int i = 0; i < 4; i++) held_cmd[i] = 1000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: disarm with reset commands, extremes, windup, arm/disarm edge
        tick_q.push_back(fixed_tick(0, 0, 0, 1500, 1000));
        tick_q.push_back(fixed_tick(0, 0, 0, 1500, 1100));
        tick_q.push_back(fixed_tick(46080, -46080, 32767, 4095, 4095));
        tick_q.push_back(fixed_tick(-46080, 46080, -32768, 0, 1500));
        tick_q.push_back(fixed_tick(-65536, 65535, -32768, 4095, 0));
        tick_q.push_back(fixed_tick(65535, -65536, 32767, 0, 1099));
        for (int i = 0; i < 8; i++) tick_q.push_back(fixed_tick(-46080, 46080, 32767, 2000, 1800));
        tick_q.push_back(fixed_tick(0, 0, 0, 1500, 1099));
        tick_q.push_back(fixed_tick(100, -100, 50, 1600, 2000));
        tick_q.push_back(fixed_tick(0, 0, 0, 1500, 1050));
        drain();

        write_reg(CFG_INNER_KD, 300);
        write_reg(CFG_OUTPUT_LIMIT, 2047);
        for (int i = 0; i < 6; i++) tick_q.push_back(rand_tick(1'b1));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_OUTER_KP, ph == 0 ? 0 : ph == 1 ? 65535 : $urandom_range(0, 1024));
            write_reg(CFG_INNER_KP, ph == 1 ? 65535 : ph == 2 ? 0 : $urandom_range(0, 512));
            write_reg(CFG_INNER_KI_RP, ph == 1 ? 65535 : $urandom_range(0, 512));
            write_reg(CFG_INNER_KI_YAW, ph == 2 ? 65535 : $urandom_range(0, 512));
            write_reg(CFG_INNER_KD, ph == 3 ? 65535 : $urandom_range(0, 64));
            write_reg(CFG_STEP_SECONDS, ph == 1 ? 24'hFFFFFF : ph == 2 ? 1 : ph == 9 ? 0
                                        : $urandom_range(1, 200000));
            write_reg(CFG_STEP_RATE_HZ, ph == 3 ? 65535 : ph == 4 ? 1 : ph == 9 ? 0
                                        : $urandom_range(1, 4000));
            write_reg(CFG_OUTPUT_LIMIT, ph == 0 ? 0 : ph == 1 ? 2047 : ph == 2 ? 2000
                                        : $urandom_range(0, 2000));
            for (int i = 0; i < 150; i++)
                tick_q.push_back(rand_tick($urandom_range(0, 9) != 0));
            if (ph == 5) hold_off = 400;
            drain();
        end

        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
